// ===== design/lpms_pkg.sv =====
// Package for the LED pattern mode sequencer.
// Holds sizes, request codes, controller types and the built-in pattern tables.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lpms_pkg;

    localparam int MODE_SLOTS    = 8;
    localparam int MAX_STEPS     = 8;
    localparam int TIME_BITS     = 16;

    localparam int MODE_W        = $clog2(MODE_SLOTS);
    localparam int STEP_W        = $clog2(MAX_STEPS);
    localparam int ADDR_W        = MODE_W + STEP_W;
    localparam int DEPTH         = MODE_SLOTS * MAX_STEPS;
    localparam int CNT_W         = $clog2(MODE_SLOTS + 1);
    localparam int LEN_W         = $clog2(MAX_STEPS + 1);

    localparam int COLOR_W       = 2;
    localparam int STIME_W       = 16;
    localparam int LOCK_W        = 16;

    localparam int BUILTIN_MODES = 4;
    localparam int FIRST_REPLACE = 5;
    localparam int MAX_NEW_LEN   = 8;
    localparam int LOCKOUT_RESET = 500;
    localparam int TIME_FAST     = 100;
    localparam int TIME_MID      = 500;
    localparam int TIME_SLOW     = 1500;

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_SELECT = 2'd1;
    localparam logic [1:0] REQ_ADD    = 2'd2;

    localparam logic [COLOR_W-1:0] COLOR_OFF    = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_RED    = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_GREEN  = 2'd2;
    localparam logic [COLOR_W-1:0] COLOR_YELLOW = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_SWITCH,
        S_WRITE,
        S_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic fin_tick;
        logic fin_switch;
        logic fin_plain;
        logic write_step;
    } t_cmd;

    typedef struct packed {
        logic sel_ok;
        logic add_ok;
        logic write_last;
        logic out_free;
    } t_status;

    function automatic logic [LEN_W-1:0] builtin_len(input logic [MODE_W-1:0] m);
        logic [LEN_W-1:0] len;
        case (m)
            MODE_W'(0): len = LEN_W'(3);
            MODE_W'(1): len = LEN_W'(6);
            MODE_W'(2): len = LEN_W'(4);
            MODE_W'(3): len = LEN_W'(5);
            default:    len = '0;
        endcase
        return len;
    endfunction

    function automatic logic [STEP_W-1:0] builtin_saved(input logic [MODE_W-1:0] m);
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] last;
        len  = builtin_len(m);
        last = len - LEN_W'(1);
        return (len == '0) ? '0 : last[STEP_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] builtin_color(input logic [ADDR_W-1:0] a);
        logic [MODE_W-1:0] m;
        logic [STEP_W-1:0] s;
        logic [15:0]       pat;
        logic [15:0]       shifted;
        m = a[ADDR_W-1:STEP_W];
        s = a[STEP_W-1:0];
        case (m)
            MODE_W'(0): pat = 16'h001B;
            MODE_W'(1): pat = 16'h0231;
            MODE_W'(2): pat = 16'h0012;
            MODE_W'(3): pat = 16'h008D;
            default:    pat = 16'h0000;
        endcase
        shifted = pat >> {s, 1'b0};
        return ({1'b0, s} < builtin_len(m)) ? shifted[COLOR_W-1:0] : COLOR_OFF;
    endfunction

    function automatic logic [STIME_W-1:0] builtin_time(input logic [ADDR_W-1:0] a);
        logic [MODE_W-1:0]  m;
        logic [STEP_W-1:0]  s;
        logic [STIME_W-1:0] t;
        m = a[ADDR_W-1:STEP_W];
        s = a[STEP_W-1:0];
        case (m)
            MODE_W'(0): t = STIME_W'(100);
            MODE_W'(1): t = STIME_W'(700);
            MODE_W'(2): t = STIME_W'(1500);
            MODE_W'(3): t = STIME_W'(2100);
            default:    t = '0;
        endcase
        return ({1'b0, s} < builtin_len(m)) ? t : '0;
    endfunction

    function automatic logic [2:0] lamp_decode(input logic [COLOR_W-1:0] c);
        logic [2:0] l;
        unique case (c)
            COLOR_RED:    l = 3'b001;
            COLOR_GREEN:  l = 3'b010;
            COLOR_YELLOW: l = 3'b100;
            default:      l = 3'b000;
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

// ===== design/led_pattern_mode_sequencer.sv =====
// Top level of the LED pattern mode sequencer: controller plus datapath.
// Tick and select words pass through accept and the step table read; a rejected or
// unknown word goes from accept to the result; an added pattern writes the table
// once per step. One word is in work at a time; a held result adds stall cycles.
// Reset is synchronous and active low; the built-in patterns are live at once.
`default_nettype none

module led_pattern_mode_sequencer import lpms_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_req_type,
    input  wire logic              i_button_pressed,
    input  wire logic [3:0]        i_mode_number,
    input  wire logic [3:0]        i_pattern_length,
    input  wire logic [15:0]       i_pattern_colors,
    input  wire logic [15:0]       i_step_time,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [LOCK_W-1:0] i_cfg_wr_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [2:0]             o_lamps,
    output logic [2:0]             o_active_mode,
    output logic [2:0]             o_active_step,
    output logic                   o_request_error,
    output logic [2:0]             o_written_slot
);

    t_cmd    cmd;
    t_status status;

    lpms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_stall    (o_stall),
        .o_cmd      (cmd)
    );

    lpms_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_type       (i_req_type),
        .i_button_pressed (i_button_pressed),
        .i_mode_number    (i_mode_number),
        .i_pattern_length (i_pattern_length),
        .i_pattern_colors (i_pattern_colors),
        .i_step_time      (i_step_time),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_lamps          (o_lamps),
        .o_active_mode    (o_active_mode),
        .o_active_step    (o_active_step),
        .o_request_error  (o_request_error),
        .o_written_slot   (o_written_slot)
    );

endmodule

`default_nettype wire

// ===== design/lpms_step_mem.sv =====
// Step table memory: color and duration of every step of every pattern slot.
// Registered read; per-entry valid bits make unwritten entries read as the
// built-in patterns from lpms_pkg.
`default_nettype none

module lpms_step_mem import lpms_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr_en,
    input  wire logic [ADDR_W-1:0]  i_wr_addr,
    input  wire logic [COLOR_W-1:0] i_wr_color,
    input  wire logic [STIME_W-1:0] i_wr_time,
    input  wire logic               i_rd_en,
    input  wire logic [ADDR_W-1:0]  i_rd_addr,
    output logic      [COLOR_W-1:0] o_rd_color,
    output logic      [STIME_W-1:0] o_rd_time
);

    logic [COLOR_W-1:0] r_color [DEPTH];
    logic [STIME_W-1:0] r_time  [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    logic [COLOR_W-1:0] r_rd_color;
    logic [STIME_W-1:0] r_rd_time;
    logic [ADDR_W-1:0]  r_rd_addr;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_color[i_wr_addr] <= i_wr_color;
            r_time[i_wr_addr]  <= i_wr_time;
        end
        if (i_rd_en) begin
            r_rd_color <= r_color[i_rd_addr];
            r_rd_time  <= r_time[i_rd_addr];
            r_rd_addr  <= i_rd_addr;
            r_rd_vld   <= r_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_color = r_rd_vld ? r_rd_color : builtin_color(r_rd_addr);
    assign o_rd_time  = r_rd_vld ? r_rd_time  : builtin_time(r_rd_addr);

endmodule

`default_nettype wire

// ===== design/lpms_ctrl.sv =====
// Controller state machine of the LED pattern mode sequencer.
// Sequences accept, table read, pattern write sweep and result hand-off.
// Depends on lpms_pkg for states, commands and status.
`default_nettype none

module lpms_ctrl import lpms_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_req_type,
    input  wire t_status    i_status,
    output logic            o_stall,
    output t_cmd            o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_req_type)
                        REQ_TICK:   n_state = S_TICK;
                        REQ_SELECT: n_state = i_status.sel_ok ? S_SWITCH : S_FIN;
                        REQ_ADD:    n_state = i_status.add_ok ? S_WRITE : S_FIN;
                        default:    n_state = S_FIN;
                    endcase
                end
            end
            S_TICK, S_SWITCH, S_FIN: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_WRITE: begin
                if (i_status.write_last) begin
                    n_state = S_FIN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE:   o_cmd.accept     = i_valid;
            S_TICK:   o_cmd.fin_tick   = i_status.out_free;
            S_SWITCH: o_cmd.fin_switch = i_status.out_free;
            S_WRITE:  o_cmd.write_step = 1'b1;
            S_FIN:    o_cmd.fin_plain  = i_status.out_free;
            default:  o_cmd            = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/lpms_datapath.sv =====
// Datapath of the LED pattern mode sequencer: timers, mode state, pattern
// bookkeeping, the step table memory and the result register.
// Depends on lpms_pkg and lpms_step_mem; driven by commands from lpms_ctrl.
`default_nettype none

module lpms_datapath import lpms_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [1:0]        i_req_type,
    input  wire logic              i_button_pressed,
    input  wire logic [3:0]        i_mode_number,
    input  wire logic [3:0]        i_pattern_length,
    input  wire logic [15:0]       i_pattern_colors,
    input  wire logic [15:0]       i_step_time,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [LOCK_W-1:0] i_cfg_wr_data,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output logic [2:0]             o_lamps,
    output logic [2:0]             o_active_mode,
    output logic [2:0]             o_active_step,
    output logic                   o_request_error,
    output logic [2:0]             o_written_slot
);

    logic [LOCK_W-1:0]    r_lockout;
    logic [TIME_BITS-1:0] r_elapsed;
    logic [TIME_BITS-1:0] r_since;
    logic [TIME_BITS-1:0] r_delay;
    logic [MODE_W-1:0]    r_mode;
    logic [STEP_W-1:0]    r_step;
    logic [CNT_W-1:0]     r_miu;
    logic [MODE_W-1:0]    r_replace;
    logic [LEN_W-1:0]     r_len_tab [MODE_SLOTS];
    logic [STEP_W-1:0]    r_saved   [MODE_SLOTS];
    logic [2:0]           r_lamps;
    logic                 r_press;
    logic                 r_err;
    logic [MODE_W-1:0]    r_wslot;
    logic [STEP_W-1:0]    r_wcnt;
    logic [LEN_W-1:0]     r_new_len;
    logic [15:0]          r_new_colors;
    logic [STIME_W-1:0]   r_new_time;
    logic                 r_out_valid;
    logic [2:0]           r_o_lamps;
    logic [2:0]           r_o_mode;
    logic [2:0]           r_o_step;
    logic                 r_o_err;
    logic [2:0]           r_o_wslot;

    logic [TIME_BITS-1:0] el_inc;
    logic [TIME_BITS-1:0] sp_inc;
    logic                 press;
    logic [MODE_W:0]      mode_inc;
    logic [MODE_W-1:0]    next_mode;
    logic [MODE_W-1:0]    sel_mode;
    logic [MODE_W-1:0]    tgt_mode;
    logic [STEP_W-1:0]    tgt_step;
    logic                 is_tick;
    logic                 is_sel;
    logic                 is_add;
    logic                 sel_ok;
    logic                 add_ok;
    logic                 switching;
    logic                 slots_full;
    logic [MODE_W-1:0]    add_slot;
    logic [MODE_W:0]      replace_inc;
    logic [MODE_W-1:0]    replace_next;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [COLOR_W-1:0]   rd_color;
    logic [STIME_W-1:0]   rd_time;
    logic [15:0]          wr_shift;
    logic [LEN_W-1:0]     wcnt_inc;
    logic [TIME_BITS-1:0] delay_now;
    logic [LEN_W-1:0]     len_now;
    logic                 fire;
    logic [LEN_W-1:0]     step_inc;
    logic [STEP_W-1:0]    step_next;
    logic                 out_free;
    logic                 finish;
    logic                 tick_fire;

    assign el_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + TIME_BITS'(1);
    assign sp_inc = (r_since == '1) ? r_since : r_since + TIME_BITS'(1);

    assign is_tick = (i_req_type == REQ_TICK);
    assign is_sel  = (i_req_type == REQ_SELECT);
    assign is_add  = (i_req_type == REQ_ADD);

    assign press = i_button_pressed && (sp_inc > r_lockout);

    assign mode_inc  = {1'b0, r_mode} + (MODE_W + 1)'(1);
    assign next_mode = (mode_inc >= r_miu) ? '0 : mode_inc[MODE_W-1:0];
    assign sel_mode  = i_mode_number[MODE_W-1:0];
    assign sel_ok    = (i_mode_number < r_miu);

    assign add_ok = (i_pattern_length >= 4'd2) && (i_pattern_length <= 4'(MAX_NEW_LEN))
        && (i_pattern_length <= MAX_STEPS)
        && ((i_step_time == 16'(TIME_FAST)) || (i_step_time == 16'(TIME_MID))
            || (i_step_time == 16'(TIME_SLOW)));

    assign tgt_mode  = is_tick ? next_mode : sel_mode;
    assign tgt_step  = (tgt_mode == r_mode) ? r_step : r_saved[tgt_mode];
    assign switching = (is_tick && press) || (is_sel && sel_ok);

    assign slots_full   = (r_miu >= MODE_SLOTS);
    assign add_slot     = slots_full ? r_replace : r_miu[MODE_W-1:0];
    assign replace_inc  = {1'b0, r_replace} + (MODE_W + 1)'(1);
    assign replace_next = (replace_inc < MODE_SLOTS) ? replace_inc[MODE_W-1:0]
                                                     : MODE_W'(FIRST_REPLACE);

    assign rd_en   = i_cmd.accept && (is_tick || (is_sel && sel_ok));
    assign rd_addr = switching ? {tgt_mode, tgt_step} : {r_mode, r_step};

    assign wr_shift = r_new_colors >> {r_wcnt, 1'b0};
    assign wcnt_inc = {1'b0, r_wcnt} + LEN_W'(1);

    lpms_step_mem u_step_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cmd.write_step),
        .i_wr_addr  ({r_wslot, r_wcnt}),
        .i_wr_color (wr_shift[COLOR_W-1:0]),
        .i_wr_time  (r_new_time),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_color (rd_color),
        .o_rd_time  (rd_time)
    );

    assign delay_now = r_press ? TIME_BITS'(rd_time) : r_delay;
    assign len_now   = r_len_tab[r_mode];
    assign fire      = (r_elapsed >= delay_now) && ({1'b0, r_step} < len_now);
    assign step_inc  = {1'b0, r_step} + LEN_W'(1);
    assign step_next = (step_inc == len_now) ? '0 : step_inc[STEP_W-1:0];
    assign tick_fire = i_cmd.fin_tick && fire;

    assign out_free = !r_out_valid || !i_stall;
    assign finish   = i_cmd.fin_tick || i_cmd.fin_switch || i_cmd.fin_plain;

    assign o_status.sel_ok     = sel_ok;
    assign o_status.add_ok     = add_ok;
    assign o_status.write_last = (wcnt_inc == r_new_len);
    assign o_status.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout <= LOCK_W'(LOCKOUT_RESET);
            r_elapsed <= '0;
            r_since   <= '0;
            r_delay   <= TIME_BITS'(TIME_FAST);
            r_mode    <= '0;
            r_step    <= '0;
            r_miu     <= CNT_W'(BUILTIN_MODES);
            r_replace <= MODE_W'(FIRST_REPLACE);
            r_lamps   <= '0;
            r_press   <= 1'b0;
            r_err     <= 1'b0;
            r_wslot   <= '0;
            r_wcnt    <= '0;
            for (int i = 0; i < MODE_SLOTS; i++) begin
                r_len_tab[i] <= builtin_len(MODE_W'(i));
                r_saved[i]   <= builtin_saved(MODE_W'(i));
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_lockout <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                r_press <= 1'b0;
                r_err   <= 1'b0;
                r_wslot <= '0;
                r_wcnt  <= '0;
                if (is_tick) begin
                    r_elapsed <= el_inc;
                    r_since   <= press ? '0 : sp_inc;
                    r_press   <= press;
                end
                if (switching) begin
                    r_saved[r_mode] <= r_step;
                    r_mode          <= tgt_mode;
                    r_step          <= tgt_step;
                end
                if (is_sel && !sel_ok) begin
                    r_err <= 1'b1;
                end
                if (is_add) begin
                    if (add_ok) begin
                        r_wslot             <= add_slot;
                        r_len_tab[add_slot] <= LEN_W'(i_pattern_length);
                        r_saved[add_slot]   <= '0;
                        if (slots_full) begin
                            r_replace <= replace_next;
                        end else begin
                            r_miu <= r_miu + CNT_W'(1);
                        end
                    end else begin
                        r_err <= 1'b1;
                    end
                end
            end
            if (i_cmd.write_step) begin
                r_wcnt <= wcnt_inc[STEP_W-1:0];
            end
            if (i_cmd.fin_tick) begin
                r_delay <= delay_now;
                if (fire) begin
                    r_lamps   <= lamp_decode(rd_color);
                    r_step    <= step_next;
                    r_elapsed <= '0;
                end
            end
            if (i_cmd.fin_switch) begin
                r_delay <= TIME_BITS'(rd_time);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && is_add && add_ok) begin
            r_new_len    <= LEN_W'(i_pattern_length);
            r_new_colors <= i_pattern_colors;
            r_new_time   <= i_step_time;
        end
        if (finish) begin
            r_o_lamps <= tick_fire ? lamp_decode(rd_color) : r_lamps;
            r_o_mode  <= 3'(r_mode);
            r_o_step  <= tick_fire ? 3'(step_next) : 3'(r_step);
            r_o_err   <= r_err;
            r_o_wslot <= 3'(r_wslot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_lamps         = r_o_lamps;
    assign o_active_mode   = r_o_mode;
    assign o_active_step   = r_o_step;
    assign o_request_error = r_o_err;
    assign o_written_slot  = r_o_wslot;

endmodule

`default_nettype wire

// ===== tb/lamp_sequencer_checker.sv =====
// Checker for the LED pattern mode sequencer: watches the request, result and setup ports.
// Keeps its own copy of the pattern tables and timers, predicts each result word and compares.
// Depends on lpms_pkg for sizes, request codes, colors and timing constants.
module lamp_sequencer_checker import lpms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_req_type,
    input  logic              i_button_pressed,
    input  logic [3:0]        i_mode_number,
    input  logic [3:0]        i_pattern_length,
    input  logic [15:0]       i_pattern_colors,
    input  logic [15:0]       i_step_time,
    input  logic              i_cfg_wr_en,
    input  logic [LOCK_W-1:0] i_cfg_wr_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [2:0]        i_lamps,
    input  logic [2:0]        i_active_mode,
    input  logic [2:0]        i_active_step,
    input  logic              i_request_error,
    input  logic [2:0]        i_written_slot,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [2:0] lamps;
        logic [2:0] mode;
        logic [2:0] step;
        logic       err;
        logic [2:0] slot;
    } t_lamp_status;

    logic [1:0]  colors_tbl [MODE_SLOTS][MAX_STEPS];
    logic [15:0] times_tbl  [MODE_SLOTS][MAX_STEPS];
    logic [3:0]  len_tbl    [MODE_SLOTS];
    logic [2:0]  saved_tbl  [MODE_SLOTS];
    int unsigned modes_used;
    logic [2:0]  next_replace;
    logic [2:0]  cur_mode;
    logic [2:0]  cur_step;
    logic [2:0]  lamp_now;
    logic [15:0] lockout;
    logic [15:0] delay_now;
    logic [15:0] elapsed;
    logic [15:0] since_press;

    t_lamp_status expected_status_q [$];
    int mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 50) begin
            $display("checker: %s mismatch at %0t: got %0d, expected %0d", what, $time, got, want);
        end
        mismatches++;
    endtask

    task automatic write_pattern(input int slot, input int len, input logic [15:0] colors,
                                 input logic [15:0] stime);
        for (int s = 0; s < len; s++) begin
            colors_tbl[slot][s] = colors[2*s +: 2];
            times_tbl[slot][s]  = stime;
        end
        len_tbl[slot] = 4'(len);
    endtask

    task automatic reset_model();
        for (int m = 0; m < MODE_SLOTS; m++) begin
            for (int s = 0; s < MAX_STEPS; s++) begin
                colors_tbl[m][s] = '0;
                times_tbl[m][s]  = '0;
            end
            len_tbl[m]   = '0;
            saved_tbl[m] = '0;
        end
        write_pattern(0, 3, 16'h001B, 16'd100);
        write_pattern(1, 6, 16'h0231, 16'd700);
        write_pattern(2, 4, 16'h0012, 16'd1500);
        write_pattern(3, 5, 16'h008D, 16'd2100);
        for (int m = 0; m < BUILTIN_MODES; m++) begin
            saved_tbl[m] = 3'(len_tbl[m] - 1);
        end
        modes_used   = BUILTIN_MODES;
        lockout      = 16'(LOCKOUT_RESET);
        next_replace = 3'(FIRST_REPLACE);
        cur_mode     = '0;
        cur_step     = '0;
        delay_now    = times_tbl[0][0];
        elapsed      = '0;
        since_press  = '0;
        lamp_now     = '0;
        expected_status_q.delete();
    endtask

    task automatic change_mode(input logic [2:0] m);
        saved_tbl[cur_mode] = cur_step;
        cur_mode  = m;
        cur_step  = saved_tbl[m];
        delay_now = times_tbl[m][cur_step];
    endtask

    task automatic predict_status(input logic [1:0] req, input logic btn,
                                  input logic [3:0] mode_no, input logic [3:0] len,
                                  input logic [15:0] colors, input logic [15:0] stime,
                                  output t_lamp_status st);
        logic       err;
        logic [2:0] slot;
        err  = 1'b0;
        slot = '0;
        case (req)
            REQ_TICK: begin
                if (elapsed != 16'hFFFF) elapsed++;
                if (since_press != 16'hFFFF) since_press++;
                if (btn && since_press > lockout) begin
                    since_press = '0;
                    change_mode(3'((cur_mode + 1) % modes_used));
                end
                if (elapsed >= delay_now && cur_step < len_tbl[cur_mode]) begin
                    case (colors_tbl[cur_mode][cur_step])
                        COLOR_RED:    lamp_now = 3'b001;
                        COLOR_GREEN:  lamp_now = 3'b010;
                        COLOR_YELLOW: lamp_now = 3'b100;
                        default:      lamp_now = 3'b000;
                    endcase
                    cur_step = 3'((cur_step + 1) % len_tbl[cur_mode]);
                    elapsed  = '0;
                end
            end
            REQ_SELECT: begin
                if (mode_no < modes_used) change_mode(mode_no[2:0]);
                else err = 1'b1;
            end
            REQ_ADD: begin
                if (len < 2 || len > MAX_NEW_LEN || len > MAX_STEPS ||
                    !(stime == TIME_FAST || stime == TIME_MID || stime == TIME_SLOW)) begin
                    err = 1'b1;
                end else begin
                    if (modes_used >= MODE_SLOTS) begin
                        slot         = next_replace;
                        next_replace = (next_replace + 1 < MODE_SLOTS) ?
                                       3'(next_replace + 1) : 3'(FIRST_REPLACE);
                    end else begin
                        slot = 3'(modes_used);
                        modes_used++;
                    end
                    write_pattern(slot, len, colors, stime);
                    saved_tbl[slot] = '0;
                end
            end
            default: ;
        endcase
        st = '{lamp_now, cur_mode, cur_step, err, slot};
    endtask

    always @(posedge i_clk) begin : monitor
        t_lamp_status got;
        t_lamp_status want;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg_wr_en) lockout = i_cfg_wr_data;
            if (i_out_valid && !i_out_stall) begin
                got = '{i_lamps, i_active_mode, i_active_step, i_request_error, i_written_slot};
                if (expected_status_q.size() == 0) begin
                    report_mismatch("result word with nothing expected", 1, 0);
                end else begin
                    want = expected_status_q.pop_front();
                    if (got.lamps !== want.lamps) report_mismatch("lamps", got.lamps, want.lamps);
                    if (got.mode !== want.mode) report_mismatch("active_mode", got.mode, want.mode);
                    if (got.step !== want.step) report_mismatch("active_step", got.step, want.step);
                    if (got.err !== want.err) report_mismatch("request_error", got.err, want.err);
                    if (got.slot !== want.slot) report_mismatch("written_slot", got.slot, want.slot);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_status(i_req_type, i_button_pressed, i_mode_number, i_pattern_length,
                               i_pattern_colors, i_step_time, want);
                expected_status_q.push_back(want);
            end
        end
        o_pending <= expected_status_q.size();
    end

endmodule

// ===== tb/tb.sv =====
// Top of the LED pattern mode sequencer testbench: clock, reset, request and setup stimulus.
// Instantiates the sequencer and lamp_sequencer_checker side by side and gives the verdict.
// Depends on lpms_pkg, led_pattern_mode_sequencer and lamp_sequencer_checker.
module tb;
    import lpms_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              i_stall = 1'b0;
    logic [1:0]        i_req_type;
    logic              i_button_pressed;
    logic [3:0]        i_mode_number;
    logic [3:0]        i_pattern_length;
    logic [15:0]       i_pattern_colors;
    logic [15:0]       i_step_time;
    logic              i_cfg_wr_en;
    logic [LOCK_W-1:0] i_cfg_wr_data;
    logic              o_stall;
    logic              o_valid;
    logic [2:0]        o_lamps;
    logic [2:0]        o_active_mode;
    logic [2:0]        o_active_step;
    logic              o_request_error;
    logic [2:0]        o_written_slot;

    int fail_count;
    int pending_words;
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;

    led_pattern_mode_sequencer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_button_pressed (i_button_pressed),
        .i_mode_number    (i_mode_number),
        .i_pattern_length (i_pattern_length),
        .i_pattern_colors (i_pattern_colors),
        .i_step_time      (i_step_time),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_lamps          (o_lamps),
        .o_active_mode    (o_active_mode),
        .o_active_step    (o_active_step),
        .o_request_error  (o_request_error),
        .o_written_slot   (o_written_slot)
    );

    lamp_sequencer_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_req_type       (i_req_type),
        .i_button_pressed (i_button_pressed),
        .i_mode_number    (i_mode_number),
        .i_pattern_length (i_pattern_length),
        .i_pattern_colors (i_pattern_colors),
        .i_step_time      (i_step_time),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_lamps          (o_lamps),
        .i_active_mode    (o_active_mode),
        .i_active_step    (o_active_step),
        .i_request_error  (o_request_error),
        .i_written_slot   (o_written_slot),
        .o_fail_count     (fail_count),
        .o_pending        (pending_words)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if ($urandom_range(1, 100) <= stall_pct) begin
            stall_left <= $urandom_range(1, 13);
            i_stall    <= 1'b1;
        end
    end

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    task automatic put_word(input logic [1:0] req, input logic btn, input logic [3:0] mode_no,
                            input logic [3:0] len, input logic [15:0] colors,
                            input logic [15:0] stime);
        int gap;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_req_type       <= req;
        i_button_pressed <= btn;
        i_mode_number    <= mode_no;
        i_pattern_length <= len;
        i_pattern_colors <= colors;
        i_step_time      <= stime;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_ticks(input int count, input int press_pct);
        repeat (count) begin
            put_word(REQ_TICK, $urandom_range(1, 100) <= press_pct, 4'($urandom), 4'($urandom),
                     16'($urandom), 16'($urandom));
        end
    endtask

    task automatic send_random_request(input int press_pct);
        int          pick;
        logic [3:0]  len;
        logic [3:0]  mode_no;
        logic [15:0] stime;
        pick = $urandom_range(1, 100);
        if (pick <= 72) begin
            send_ticks(1, press_pct);
        end else if (pick <= 84) begin
            mode_no = ($urandom_range(1, 100) <= 85) ? 4'($urandom_range(0, MODE_SLOTS - 1))
                                                      : 4'($urandom);
            put_word(REQ_SELECT, 1'($urandom), mode_no, 4'($urandom), 16'($urandom),
                     16'($urandom));
        end else if (pick <= 97) begin
            if ($urandom_range(1, 100) <= 80) begin
                len = 4'($urandom_range(2, MAX_NEW_LEN));
                case ($urandom_range(0, 2))
                    0: stime = 16'(TIME_FAST);
                    1: stime = 16'(TIME_MID);
                    default: stime = 16'(TIME_SLOW);
                endcase
            end else begin
                len = 4'($urandom);
                case ($urandom_range(0, 2))
                    0: stime = 16'($urandom);
                    1: stime = 16'(TIME_FAST + 1);
                    default: stime = 16'(TIME_SLOW - 1);
                endcase
            end
            put_word(REQ_ADD, 1'($urandom), 4'($urandom), len, 16'($urandom), stime);
        end else begin
            put_word(REQ_UNUSED, 1'($urandom), 4'($urandom), 4'($urandom), 16'($urandom),
                     16'($urandom));
        end
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
    endtask

    task automatic set_lockout(input logic [15:0] value);
        i_valid <= 1'b0;
        wait_drained();
        repeat (12) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int press_pct;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_req_type       = REQ_TICK;
        i_button_pressed = 1'b0;
        i_mode_number    = '0;
        i_pattern_length = '0;
        i_pattern_colors = '0;
        i_step_time      = '0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_wr_data    = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct = 20;
        stall_pct <= 20;
        put_word(REQ_TICK, 1'b1, 4'd0, 4'd0, 16'h0000, 16'h0000);
        put_word(REQ_SELECT, 1'b0, 4'd15, 4'd0, 16'h0000, 16'h0000);
        put_word(REQ_SELECT, 1'b0, 4'd4, 4'd0, 16'h0000, 16'h0000);
        put_word(REQ_SELECT, 1'b0, 4'd3, 4'd0, 16'h0000, 16'h0000);
        put_word(REQ_SELECT, 1'b0, 4'd0, 4'd0, 16'h0000, 16'h0000);
        put_word(REQ_UNUSED, 1'b1, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF);
        put_word(REQ_ADD, 1'b0, 4'd0, 4'd0, 16'hFFFF, 16'(TIME_FAST));
        put_word(REQ_ADD, 1'b0, 4'd0, 4'd1, 16'hFFFF, 16'(TIME_FAST));
        put_word(REQ_ADD, 1'b0, 4'd0, 4'd9, 16'hFFFF, 16'(TIME_FAST));
        put_word(REQ_ADD, 1'b0, 4'd0, 4'd15, 16'hFFFF, 16'(TIME_FAST));
        put_word(REQ_ADD, 1'b0, 4'd0, 4'd8, 16'hFFFF, 16'(TIME_FAST - 1));
        put_word(REQ_ADD, 1'b0, 4'd0, 4'd8, 16'hFFFF, 16'h0000);
        put_word(REQ_ADD, 1'b0, 4'd0, 4'd8, 16'hFFFF, 16'hFFFF);
        put_word(REQ_ADD, 1'b0, 4'd0, 4'd2, 16'hFFFF, 16'(TIME_FAST));
        put_word(REQ_ADD, 1'b0, 4'd0, 4'd8, 16'hE4E4, 16'(TIME_MID));
        put_word(REQ_ADD, 1'b0, 4'd0, 4'd8, 16'h1B1B, 16'(TIME_SLOW));
        put_word(REQ_ADD, 1'b0, 4'd0, 4'd5, 16'h0000, 16'(TIME_FAST));
        put_word(REQ_SELECT, 1'b0, 4'd5, 4'd0, 16'h0000, 16'h0000);
        put_word(REQ_ADD, 1'b0, 4'd0, 4'd3, 16'h0039, 16'(TIME_FAST));
        put_word(REQ_SELECT, 1'b0, 4'd8, 4'd0, 16'h0000, 16'h0000);
        put_word(REQ_SELECT, 1'b0, 4'd7, 4'd0, 16'h0000, 16'h0000);
        put_word(REQ_TICK, 1'b1, 4'd0, 4'd0, 16'h0000, 16'h0000);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_lockout(16'd0);
                1: set_lockout(16'hFFFF);
                2: set_lockout(16'd1);
                3: set_lockout(16'($urandom_range(2, 300)));
                4: set_lockout(16'd37);
                default: set_lockout(16'(LOCKOUT_RESET));
            endcase
            gap_pct = pick_idle_pct();
            stall_pct <= pick_idle_pct();
            press_pct = $urandom_range(5, 60);
            repeat (90) send_random_request(press_pct);
        end

        // Leave a rewritten, shorter pattern playing past its end so no step is shown.
        gap_pct = 0;
        stall_pct <= 0;
        set_lockout(16'hFFFF);
        put_word(REQ_SELECT, 1'b0, 4'd0, 4'd0, 16'h0000, 16'h0000);
        repeat (3) put_word(REQ_ADD, 1'b0, 4'd0, 4'd8, 16'($urandom), 16'(TIME_FAST));
        put_word(REQ_SELECT, 1'b0, 4'd5, 4'd0, 16'h0000, 16'h0000);
        send_ticks(250, 50);
        repeat (3) put_word(REQ_ADD, 1'b0, 4'd0, 4'd2, 16'($urandom), 16'(TIME_FAST));
        send_ticks(100, 30);
        set_lockout(16'hFFFE);
        send_ticks(40, 100);

        i_valid <= 1'b0;
        wait_drained();
        repeat (12) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
